[rtl/rcpa_pkg.sv]
// ----------------------------------------------------------------------------
// rcpa_pkg
// Shared opcodes and status codes of the reference-counted page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpa_pkg;

  localparam int OP_W     = 2;
  localparam int PAGE_W   = 16;  // in_page_number width
  localparam int GRANT_W  = 15;  // out_granted_page width
  localparam int COUNT_W  = 8;   // out_count_after width
  localparam int FUP_W    = 15;  // first_usable_page width

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_INCREF = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_OOM  = 3'd1,
    ST_BAD  = 3'd2,
    ST_SAT  = 3'd3,
    ST_FULL = 3'd4
  } status_t;

endpackage

`default_nettype wire

[rtl/refcounted_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// refcounted_page_allocator_top
// Free-list page allocator with a reference count per page.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_opcode / in_page_number and raise start; the
//   beat is taken at an edge where start is high and busy is low.
//   Result channel: out_valid strobes for exactly one cycle with status,
//   granted_page, count_after and released. The receiver cannot stall it.
//   Config channel: cfg_valid / cfg_ready beat carrying first_usable_page;
//   a write empties the freed stack, rewinds the watermark and clears the
//   counts of pages first_usable_page..NUM_PAGES-1.
// Timing:
//   The count memory and the stack memory are read at the accept edge, then
//   modified and written back in the next cycle. out_valid is registered
//   from exec_r, which is registered from accept. busy is high for one
//   cycle per command, so a new command is taken only once the last one
//   has been written back.
//   After reset the count memory is swept to zero with busy high; a config
//   write sweeps down to first_usable_page, or to a lower pending bound.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_allocator_top #(
  parameter int NUM_PAGES = 32768,
  parameter int MAX_COUNT = 255
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rcpa_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [rcpa_pkg::PAGE_W-1:0]    in_page_number,
  output logic                                out_valid,
  output logic      [2:0]                     out_status,
  output logic      [rcpa_pkg::GRANT_W-1:0]   out_granted_page,
  output logic      [rcpa_pkg::COUNT_W-1:0]   out_count_after,
  output logic                                out_released,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rcpa_pkg::FUP_W-1:0]     cfg_first_usable_page
);

  localparam int PG_W  = $clog2(NUM_PAGES);
  localparam int NW    = $clog2(NUM_PAGES + 1);           // stack depth width
  localparam int XW    = (NW > rcpa_pkg::PAGE_W) ? NW : rcpa_pkg::PAGE_W;
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int CXW   = (CNT_W > rcpa_pkg::COUNT_W) ? CNT_W : rcpa_pkg::COUNT_W;
  localparam int GXW   = (PG_W > rcpa_pkg::GRANT_W) ? PG_W : rcpa_pkg::GRANT_W;

  // ---------------------------------------------------------------- control
  logic                          accept;
  logic                          cfg_wr;
  logic                          exec_r;
  rcpa_pkg::opcode_t             op_r;
  logic [rcpa_pkg::PAGE_W-1:0]   pg_r;
  logic [NW-1:0]                 depth_r, depth_nxt;
  logic [PG_W-1:0]               wm_r, wm_nxt;
  logic                          fe_r, fe_nxt;
  logic [rcpa_pkg::FUP_W-1:0]    fup_r;

  logic                          clr_active;
  logic [PG_W-1:0]               clr_addr;

  // memories
  logic                          cnt_we;
  logic [PG_W-1:0]               cnt_waddr;
  logic [CNT_W-1:0]              cnt_wdata;
  logic [PG_W-1:0]               cnt_raddr;
  logic [CNT_W-1:0]              cnt_rdata;
  logic                          stk_we;
  logic [PG_W-1:0]               stk_raddr;
  logic [PG_W-1:0]               stk_rdata;

  // exec stage
  logic                          ex_we;
  logic [PG_W-1:0]               ex_waddr;
  logic [CNT_W-1:0]              ex_wdata;
  rcpa_pkg::status_t             st_nxt;
  logic [PG_W-1:0]               grant_nxt;
  logic [CNT_W-1:0]              cnt_nxt;
  logic                          rel_nxt;
  logic [PG_W-1:0]               pg_idx;
  logic                          pg_bad;
  logic                          pg_low;
  logic [PG_W-1:0]               got;

  logic                          out_valid_r;
  rcpa_pkg::status_t             out_status_r;
  logic [rcpa_pkg::GRANT_W-1:0]  out_grant_r;
  logic [rcpa_pkg::COUNT_W-1:0]  out_count_r;
  logic                          out_rel_r;

  logic [GXW-1:0]                grant_x;
  logic [CXW-1:0]                count_x;
  logic [XW-1:0]                 in_pg_x;
  logic [XW-1:0]                 pg_x;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign busy      = exec_r | clr_active;
  assign accept    = start & ~busy;

  // --------------------------------------------------------------- memories
  assign in_pg_x   = XW'(in_page_number);
  assign cnt_raddr = in_pg_x[PG_W-1:0];
  assign stk_raddr = PG_W'(depth_r - NW'(1));  // top of stack, for a pop

  assign cnt_we    = clr_active | ex_we;
  assign cnt_waddr = clr_active ? clr_addr : ex_waddr;
  assign cnt_wdata = clr_active ? '0 : ex_wdata;

  rcpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (CNT_W)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rcpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PG_W)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[PG_W-1:0]),
    .wdata (pg_idx),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  rcpa_clr #(
    .NUM_PAGES (NUM_PAGES)
  ) u_clr (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .restart_lo (cfg_first_usable_page),
    .active     (clr_active),
    .addr       (clr_addr)
  );

  // ------------------------------------------------------------ exec stage
  assign pg_x   = XW'(pg_r);
  assign pg_idx = pg_x[PG_W-1:0];
  assign pg_bad = (pg_x >= XW'(NUM_PAGES));
  assign pg_low = (pg_x < XW'(fup_r));

  always_comb begin
    ex_we     = 1'b0;
    ex_waddr  = pg_idx;
    ex_wdata  = '0;
    stk_we    = 1'b0;
    depth_nxt = depth_r;
    wm_nxt    = wm_r;
    fe_nxt    = fe_r;
    st_nxt    = rcpa_pkg::ST_OK;
    grant_nxt = '0;
    cnt_nxt   = '0;
    rel_nxt   = 1'b0;
    got       = stk_rdata;
    if (exec_r) begin
      case (op_r)
        rcpa_pkg::OP_ALLOC: begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - NW'(1);
          end else if (!fe_r) begin
            got = wm_r;
            if (XW'(wm_r) <= XW'(fup_r)) begin
              fe_nxt = 1'b1;
            end else begin
              wm_nxt = wm_r - PG_W'(1);
            end
          end
          if (depth_r == '0 && fe_r) begin
            st_nxt = rcpa_pkg::ST_OOM;
          end else begin
            ex_we     = 1'b1;
            ex_waddr  = got;
            ex_wdata  = CNT_W'(1);
            grant_nxt = got;
            cnt_nxt   = CNT_W'(1);
          end
        end
        rcpa_pkg::OP_INCREF: begin
          if (pg_bad) begin
            st_nxt = rcpa_pkg::ST_BAD;
          end else if (cnt_rdata >= CNT_W'(MAX_COUNT)) begin
            st_nxt  = rcpa_pkg::ST_SAT;
            cnt_nxt = cnt_rdata;
          end else begin
            ex_we    = 1'b1;
            ex_wdata = cnt_rdata + CNT_W'(1);
            cnt_nxt  = cnt_rdata + CNT_W'(1);
          end
        end
        rcpa_pkg::OP_FREE: begin
          if (pg_bad || pg_low) begin
            st_nxt = rcpa_pkg::ST_BAD;
          end else if (cnt_rdata > CNT_W'(1)) begin
            ex_we    = 1'b1;
            ex_wdata = cnt_rdata - CNT_W'(1);
            cnt_nxt  = cnt_rdata - CNT_W'(1);
          end else if (depth_r == NW'(NUM_PAGES)) begin
            st_nxt  = rcpa_pkg::ST_FULL;
            cnt_nxt = cnt_rdata;
          end else begin
            // last reference gone (or already zero): push the page
            ex_we     = 1'b1;
            stk_we    = 1'b1;
            depth_nxt = depth_r + NW'(1);
            rel_nxt   = 1'b1;
          end
        end
        default: begin
          st_nxt = rcpa_pkg::ST_BAD;
        end
      endcase
    end
  end

  assign grant_x = GXW'(grant_nxt);
  assign count_x = CXW'(cnt_nxt);

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r      <= 1'b0;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      wm_r        <= PG_W'(NUM_PAGES - 1);
      fe_r        <= 1'b0;
      fup_r       <= '0;
    end else begin
      exec_r      <= accept;
      out_valid_r <= exec_r;
      if (cfg_wr) begin
        fup_r   <= cfg_first_usable_page;
        depth_r <= '0;
        wm_r    <= PG_W'(NUM_PAGES - 1);
        fe_r    <= (XW'(cfg_first_usable_page) >= XW'(NUM_PAGES));
      end else begin
        depth_r <= depth_nxt;
        wm_r    <= wm_nxt;
        fe_r    <= fe_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= rcpa_pkg::opcode_t'(in_opcode);
      pg_r <= in_page_number;
    end
    if (exec_r) begin
      out_status_r <= st_nxt;
      out_grant_r  <= grant_x[rcpa_pkg::GRANT_W-1:0];
      out_count_r  <= count_x[rcpa_pkg::COUNT_W-1:0];
      out_rel_r    <= rel_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_page = out_grant_r;
  assign out_count_after  = out_count_r;
  assign out_released     = out_rel_r;

endmodule

`default_nettype wire

[rtl/rcpa_ram.sv]
// ----------------------------------------------------------------------------
// rcpa_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered (old data on a same-address hit).
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/rcpa_clr.sv]
// ----------------------------------------------------------------------------
// rcpa_clr
// Count memory clearing sweep. Walks from the top page down to the lower
// bound, one entry per cycle. After reset the bound is page 0; a restart
// from a register write uses the new first usable page, unless a sweep
// still running has a lower bound, which is then kept.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_clr #(
  parameter int NUM_PAGES = 32768
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 restart,
  input  wire logic [rcpa_pkg::FUP_W-1:0]           restart_lo,
  output logic                                      active,
  output logic      [$clog2(NUM_PAGES)-1:0]         addr
);

  localparam int PG_W = $clog2(NUM_PAGES);
  localparam int NW   = $clog2(NUM_PAGES + 1);
  localparam int XW   = (NW > rcpa_pkg::PAGE_W) ? NW : rcpa_pkg::PAGE_W;

  logic                        active_r, active_nxt;
  logic                        full_r, full_nxt;
  logic [PG_W-1:0]             addr_r, addr_nxt;
  logic [rcpa_pkg::FUP_W-1:0]  lo_r, lo_nxt;

  always_comb begin
    active_nxt = active_r;
    full_nxt   = full_r;
    addr_nxt   = addr_r;
    lo_nxt     = lo_r;
    if (restart) begin
      addr_nxt = PG_W'(NUM_PAGES - 1);
      if (full_r) begin
        active_nxt = 1'b1;
        lo_nxt     = '0;
      end else if (active_r && (lo_r < restart_lo)) begin
        // pages of the unfinished sweep still need clearing
        active_nxt = 1'b1;
        lo_nxt     = lo_r;
      end else begin
        // nothing to clear when the pool starts above the top page
        active_nxt = (XW'(restart_lo) < XW'(NUM_PAGES));
        lo_nxt     = restart_lo;
      end
    end else if (active_r) begin
      if (XW'(addr_r) <= XW'(lo_r)) begin
        active_nxt = 1'b0;
        full_nxt   = 1'b0;
      end else begin
        addr_nxt = addr_r - PG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      full_r   <= 1'b1;
      addr_r   <= PG_W'(NUM_PAGES - 1);
      lo_r     <= '0;
    end else begin
      active_r <= active_nxt;
      full_r   <= full_nxt;
      addr_r   <= addr_nxt;
      lo_r     <= lo_nxt;
    end
  end

  assign active = active_r;
  assign addr   = addr_r;

endmodule

`default_nettype wire
